>>> hw/rtl/multi_column_row_match_lookup_top_defines.svh
// Assertion macros for the row match lookup block.
// Included by the RTL files that assert; no other dependencies.
`ifndef MULTI_COLUMN_ROW_MATCH_LOOKUP_TOP_DEFINES_SVH
`define MULTI_COLUMN_ROW_MATCH_LOOKUP_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define MCRML_ASSERT(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed");
`define MCRML_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define MCRML_ASSERT(label, clk, rst_n, expr)
`define MCRML_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/mcrml_pkg.sv
// Shared types, codes and helpers for the row match lookup block.
// No dependencies.
`default_nettype none
package mcrml_pkg;

	localparam int FuncW    = 2;
	localparam int KeyW     = 32;
	localparam int KeyColsW = 3;
	localparam int NumLanes = 4;
	localparam int MaxColumns = 4;

	localparam logic [FuncW-1:0] FuncLoad  = 2'd0;
	localparam logic [FuncW-1:0] FuncQuery = 2'd1;
	localparam logic [FuncW-1:0] FuncClear = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	typedef struct packed {
		logic clr;
		logic vld;
	} merge_ctrl_t;

	// leading-column mask; count saturated to 1..MaxColumns
	function automatic logic [NumLanes-1:0] active_mask(input logic [KeyColsW-1:0] kc);
		logic [KeyColsW-1:0] n;
		logic [NumLanes-1:0] m;
		n = kc;
		if (n < KeyColsW'(1))
			n = KeyColsW'(1);
		if (n > KeyColsW'(MaxColumns))
			n = KeyColsW'(MaxColumns);
		for (int k = 0; k < NumLanes; k++)
			m[k] = (KeyColsW'(k) < n);
		return m;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/mcrml_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mcrml_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> hw/rtl/mcrml_lane.sv
// One key column lane: column memory, query key register and compare stage.
// Depends on mcrml_pkg and mcrml_ram.
`default_nettype none
module mcrml_lane #(
	parameter int DEPTH = 256
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [$clog2(DEPTH)-1:0]      waddr,
	input  wire logic [mcrml_pkg::KeyW-1:0]    wdata,
	input  wire logic [$clog2(DEPTH)-1:0]      raddr,
	input  wire logic                          key_ld,
	output logic                               match_s2
);
	import mcrml_pkg::*;

	logic [KeyW-1:0] rdata_s1;
	logic [KeyW-1:0] key_q;

	mcrml_ram #(
		.WIDTH(KeyW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_s1)
	);

	always_ff @(posedge clk) begin
		if (key_ld)
			key_q <= wdata;
		match_s2 <= (rdata_s1 == key_q);
	end

endmodule
`default_nettype wire

>>> hw/rtl/mcrml_merge.sv
// Merge stage: combines lane matches and keeps the last matching position.
// Depends on mcrml_pkg.
`default_nettype none
module mcrml_merge #(
	parameter int DEPTH = 256
) (
	input  wire logic                             clk,
	input  wire mcrml_pkg::merge_ctrl_t           ctrl,
	input  wire logic [mcrml_pkg::NumLanes-1:0]   match,
	input  wire logic [mcrml_pkg::NumLanes-1:0]   mask,
	input  wire logic [$clog2(DEPTH)-1:0]         idx,
	output logic      [$clog2(DEPTH+1)-1:0]       pos_q
);
	import mcrml_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic row_hit;

	assign row_hit = &(match | ~mask);

	always_ff @(posedge clk) begin
		if (ctrl.clr)
			pos_q <= '0;
		else if (ctrl.vld && row_hit)
			pos_q <= CW'(idx) + CW'(1);
	end

endmodule
`default_nettype wire

>>> hw/rtl/multi_column_row_match_lookup_top.sv
// Row match lookup over a table of multi-column integer keys.
// Words on in_* carry func and four key columns; results leave on out_*.
// A load word appends one row (all four columns) and returns one result word
// with overflow set if the table already held TABLE_DEPTH rows.
// A query word returns found and the 1-based position of the last stored
// row whose leading key_columns columns equal the query; 0 if none.
// A clear word empties the table and returns nothing; func 3 is ignored.
// One word is in work at a time. A load's result passes through the DONE state
// into the output register; a query's result comes from the four column
// memories reading one row per cycle in parallel lanes into the merge stage.
// in_ready is high only between words; it rises again once the result has
// moved to the output register, so the next word may enter while that result
// waits on out_ready. A stalled result holds until taken.
// Reset empties the table and sets key_columns to 1; no clearing pass runs.
// cfg_we/cfg_wdata write key_columns; write only while the block is idle.
// Depends on mcrml_pkg, mcrml_lane, mcrml_merge and the defines header.
`default_nettype none
`include "multi_column_row_match_lookup_top_defines.svh"
module multi_column_row_match_lookup_top #(
	parameter int TABLE_DEPTH = 256
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [mcrml_pkg::KeyColsW-1:0]      cfg_wdata,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [mcrml_pkg::FuncW-1:0]         func,
	input  wire logic signed [mcrml_pkg::KeyW-1:0]   col_a,
	input  wire logic signed [mcrml_pkg::KeyW-1:0]   col_b,
	input  wire logic signed [mcrml_pkg::KeyW-1:0]   col_c,
	input  wire logic signed [mcrml_pkg::KeyW-1:0]   col_d,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     found,
	output logic [$clog2(TABLE_DEPTH+1)-1:0]         position,
	output logic                                     overflow
);
	import mcrml_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t                state_q;
	logic [KeyColsW-1:0]   key_columns_q;
	logic [CW-1:0]         row_count_q;
	logic [CW-1:0]         scan_cnt_q;
	logic                  vld_s1, vld_s2;
	logic [AW-1:0]         idx_s1, idx_s2;
	logic                  is_load_q, ovf_q;
	logic                  out_valid_q, out_found_q, out_ovf_q;
	logic [CW-1:0]         out_pos_q;

	logic                  accept, full, issue, scan_done, do_load, do_query, out_free;
	logic [KeyW-1:0]       col_v [NumLanes];
	logic [NumLanes-1:0]   match_s2;
	logic [CW-1:0]         merge_pos;
	merge_ctrl_t           mctrl;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = (row_count_q == CW'(TABLE_DEPTH));
	assign do_load   = accept && (func == FuncLoad);
	assign do_query  = accept && (func == FuncQuery);
	assign issue     = (state_q == ST_SCAN) && (scan_cnt_q < row_count_q);
	assign scan_done = (state_q == ST_SCAN) && !issue && !vld_s1 && !vld_s2;
	assign out_free  = !out_valid_q || out_ready;

	assign col_v[0] = col_a;
	assign col_v[1] = col_b;
	assign col_v[2] = col_c;
	assign col_v[3] = col_d;

	for (genvar g = 0; g < NumLanes; g++) begin : g_lane
		mcrml_lane #(
			.DEPTH(TABLE_DEPTH)
		) u_lane (
			.clk     (clk),
			.we      (do_load && !full),
			.waddr   (row_count_q[AW-1:0]),
			.wdata   (col_v[g]),
			.raddr   (scan_cnt_q[AW-1:0]),
			.key_ld  (do_query),
			.match_s2(match_s2[g])
		);
	end

	assign mctrl.clr = do_query;
	assign mctrl.vld = vld_s2;

	mcrml_merge #(
		.DEPTH(TABLE_DEPTH)
	) u_merge (
		.clk  (clk),
		.ctrl (mctrl),
		.match(match_s2),
		.mask (active_mask(key_columns_q)),
		.idx  (idx_s2),
		.pos_q(merge_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			key_columns_q <= KeyColsW'(1);
			row_count_q   <= '0;
			scan_cnt_q    <= '0;
			vld_s1        <= 1'b0;
			vld_s2        <= 1'b0;
			is_load_q     <= 1'b0;
			ovf_q         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we)
				key_columns_q <= cfg_wdata;
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			if (issue)
				scan_cnt_q <= scan_cnt_q + CW'(1);
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func)
							FuncLoad: begin
								is_load_q <= 1'b1;
								ovf_q     <= full;
								if (!full)
									row_count_q <= row_count_q + CW'(1);
								state_q <= ST_DONE;
							end
							FuncQuery: begin
								is_load_q  <= 1'b0;
								ovf_q      <= 1'b0;
								scan_cnt_q <= '0;
								state_q    <= ST_SCAN;
							end
							FuncClear: row_count_q <= '0;
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_done)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_cnt_q[AW-1:0];
		idx_s2 <= idx_s1;
		if (state_q == ST_DONE && out_free) begin
			out_found_q <= !is_load_q && (merge_pos != '0);
			out_pos_q   <= is_load_q ? '0 : merge_pos;
			out_ovf_q   <= is_load_q && ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = out_found_q;
	assign position  = out_pos_q;
	assign overflow  = out_ovf_q;

	`MCRML_ASSERT(a_state_onehot, clk, arst_n, $onehot(state_q))
	`MCRML_ASSERT(a_count_bound, clk, arst_n, row_count_q <= CW'(TABLE_DEPTH))
	`MCRML_ASSERT_IMPLY(a_pipe_in_scan, clk, arst_n, vld_s1 || vld_s2, state_q == ST_SCAN)
	`MCRML_ASSERT_IMPLY(a_scan_bound, clk, arst_n, state_q == ST_SCAN, scan_cnt_q <= row_count_q)
	`MCRML_ASSERT_IMPLY(a_found_pos, clk, arst_n, out_valid_q && out_found_q,
		out_pos_q != '0 && !out_ovf_q)

endmodule
`default_nettype wire

>>> tb/sv/multi_column_row_match_lookup_top_test.sv
// Self-checking testbench for multi_column_row_match_lookup_top: load, query, clear and
// ignored words against a behavioral table mirror, with random idling on both channels.
// Depends on mcrml_pkg and the RTL of the block; reads no files.
`timescale 1ns / 100ps
module multi_column_row_match_lookup_top_test;
	import mcrml_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int DEPTH        = 256;
	localparam int PosW         = $clog2(DEPTH + 1);
	localparam int DRAIN_CYCLES = DEPTH + 16;
	localparam int STALL_LIMIT  = 4000;
	localparam int PHASE_WORDS  = 75;
	localparam logic [FuncW-1:0] FuncIgnored = 2'd3;

	typedef logic [NumLanes-1:0][KeyW-1:0] key_row_t;

	typedef struct packed {
		logic [FuncW-1:0] op;
		key_row_t         key;
	} lookup_word_t;

	typedef struct packed {
		logic            found;
		logic [PosW-1:0] position;
		logic            overflow;
	} lookup_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [KeyColsW-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [FuncW-1:0] func;
	logic signed [KeyW-1:0] col_a, col_b, col_c, col_d;
	logic out_valid;
	logic out_ready;
	logic found;
	logic [PosW-1:0] position;
	logic overflow;

	lookup_word_t   pending_words[$];
	lookup_result_t expected_results[$];
	key_row_t       queued_rows[$];

	key_row_t stored_keys [DEPTH];
	int unsigned stored_count;
	logic [KeyColsW-1:0] key_cols_mirror;

	lookup_word_t drv_word;
	bit drv_busy;
	bit in_word_taken;
	bit calm;
	int in_gap;
	int out_hold;
	int stall_cycles;
	int failures;
	int mismatches;

	logic [KeyColsW-1:0] cfg_plan [8] = '{3'd0, 3'd7, 3'd2, 3'd3, 3'd1, 3'd5, 3'd6, 3'd4};

	multi_column_row_match_lookup_top #(
		.TABLE_DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.col_a(col_a),
		.col_b(col_b),
		.col_c(col_c),
		.col_d(col_d),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.position(position),
		.overflow(overflow)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic void predict_lookup(logic [FuncW-1:0] op, key_row_t key);
		lookup_result_t res;
		int ncols;
		bit hit;
		res = '0;
		case (op)
			FuncLoad: begin
				if (stored_count < DEPTH) begin
					stored_keys[stored_count] = key;
					stored_count++;
				end else begin
					res.overflow = 1'b1;
				end
				expected_results.push_back(res);
			end
			FuncQuery: begin
				ncols = int'(key_cols_mirror);
				if (ncols < 1)
					ncols = 1;
				if (ncols > MaxColumns)
					ncols = MaxColumns;
				if (ncols > NumLanes)
					ncols = NumLanes;
				for (int r = 0; r < stored_count; r++) begin
					hit = 1'b1;
					for (int k = 0; k < ncols; k++)
						if (stored_keys[r][k] !== key[k])
							hit = 1'b0;
					if (hit)
						res.position = PosW'(r + 1);
				end
				res.found = (res.position != '0);
				expected_results.push_back(res);
			end
			FuncClear: begin
				stored_count = 0;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_result();
		lookup_result_t got, want;
		got = '{found: found, position: position, overflow: overflow};
		if (expected_results.size() == 0) begin
			failures++;
			if (mismatches < 10)
				$display("unexpected result word: found=%0d position=%0d overflow=%0d",
					got.found, got.position, got.overflow);
			mismatches++;
		end else begin
			want = expected_results.pop_front();
			if (got.found !== want.found || got.position !== want.position ||
					got.overflow !== want.overflow) begin
				failures++;
				if (mismatches < 10)
					$display("mismatch: expected found=%0d position=%0d overflow=%0d, got found=%0d position=%0d overflow=%0d",
						want.found, want.position, want.overflow,
						got.found, got.position, got.overflow);
				mismatches++;
			end
		end
	endfunction

	// monitor: inputs and outputs sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			stall_cycles++;
			if (in_valid && in_ready) begin
				in_word_taken = 1'b1;
				stall_cycles = 0;
				predict_lookup(func, {col_d, col_c, col_b, col_a});
			end
			if (out_valid && out_ready) begin
				stall_cycles = 0;
				check_result();
			end
		end
	end

	// driver: inputs change at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_word_taken) begin
				in_word_taken = 1'b0;
				drv_busy = 1'b0;
				if (!calm && $urandom_range(0, 4) == 0)
					in_gap = $urandom_range(1, 16);
			end
			if (!drv_busy) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (pending_words.size() > 0) begin
					drv_word = pending_words.pop_front();
					drv_busy = 1'b1;
				end
			end
			in_valid <= drv_busy;
			func <= drv_word.op;
			col_a <= drv_word.key[0];
			col_b <= drv_word.key[1];
			col_c <= drv_word.key[2];
			col_d <= drv_word.key[3];

			if (out_hold > 0) begin
				out_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0)
					out_hold = $urandom_range(1, 16);
			end
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic void queue_word(logic [FuncW-1:0] op, key_row_t key);
		lookup_word_t w;
		w.op = op;
		w.key = key;
		pending_words.push_back(w);
		if (op == FuncLoad && queued_rows.size() < DEPTH)
			queued_rows.push_back(key);
		else if (op == FuncClear)
			queued_rows.delete();
	endfunction

	function automatic logic [KeyW-1:0] random_key();
		int roll;
		roll = $urandom_range(0, 9);
		case (roll)
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			4, 5: return KeyW'($urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	function automatic key_row_t random_row();
		key_row_t row;
		for (int k = 0; k < NumLanes; k++)
			row[k] = random_key();
		return row;
	endfunction

	// mostly copies of queued rows, sometimes with one column changed
	function automatic key_row_t random_query();
		key_row_t row;
		if (queued_rows.size() == 0 || $urandom_range(0, 9) < 4)
			return random_row();
		row = queued_rows[$urandom_range(0, queued_rows.size() - 1)];
		if ($urandom_range(0, 99) < 35)
			row[$urandom_range(0, NumLanes - 1)] = random_key();
		return row;
	endfunction

	task automatic settle();
		while (pending_words.size() > 0 || drv_busy || expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_key_columns(logic [KeyColsW-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		key_cols_mirror = value;
	endtask

	task automatic directed_words();
		queue_word(FuncQuery, '0);
		queue_word(FuncLoad, '0);
		queue_word(FuncLoad, {4{32'hffff_ffff}});
		queue_word(FuncLoad, {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
		queue_word(FuncLoad, {32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
		queue_word(FuncLoad, {32'd3, 32'd2, 32'd1, 32'd0});
		queue_word(FuncQuery, {32'd9, 32'd9, 32'd9, 32'd0});
		queue_word(FuncQuery, {4{32'hffff_ffff}});
		queue_word(FuncQuery, {32'd0, 32'd0, 32'd0, 32'h8000_0000});
		queue_word(FuncQuery, {32'd0, 32'd0, 32'd0, 32'h7fff_ffff});
		queue_word(FuncQuery, {32'd0, 32'd0, 32'd0, 32'd5});
		queue_word(FuncIgnored, {32'd8, 32'd7, 32'd6, 32'd5});
		queue_word(FuncQuery, {32'd0, 32'd0, 32'd0, 32'd5});
		queue_word(FuncLoad, {32'd8, 32'd7, 32'd6, 32'd5});
		queue_word(FuncQuery, {32'd0, 32'd0, 32'd0, 32'd5});
		queue_word(FuncClear, '0);
		queue_word(FuncQuery, '0);
		queue_word(FuncLoad, {32'hf0f0_f0f0, 32'h0f0f_0f0f, 32'h9abc_def0, 32'h1234_5678});
		queue_word(FuncQuery, {32'hf0f0_f0f0, 32'h0f0f_0f0f, 32'h9abc_def0, 32'h1234_5678});
	endtask

	// fill the table, run past capacity, then clear from full
	task automatic fill_past_capacity();
		queue_word(FuncClear, '0);
		for (int i = 0; i < DEPTH; i++) begin
			if (i == DEPTH - 1)
				queue_word(FuncLoad, queued_rows[0]);
			else
				queue_word(FuncLoad, random_row());
			if ($urandom_range(0, 15) == 0)
				queue_word(FuncQuery, random_query());
		end
		for (int i = 0; i < 4; i++)
			queue_word(FuncLoad, random_row());
		queue_word(FuncQuery, queued_rows[0]);
		queue_word(FuncQuery, queued_rows[DEPTH / 2]);
		queue_word(FuncQuery, random_row());
		queue_word(FuncClear, '0);
		queue_word(FuncLoad, random_row());
		queue_word(FuncQuery, queued_rows[0]);
		queue_word(FuncClear, '0);
	endtask

	task automatic random_phase(int count);
		int roll;
		key_row_t row;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 46) begin
				if (queued_rows.size() > 0 && $urandom_range(0, 4) == 0)
					row = random_query();
				else
					row = random_row();
				queue_word(FuncLoad, row);
			end else if (roll < 94) begin
				queue_word(FuncQuery, random_query());
			end else if (roll < 97) begin
				queue_word(FuncClear, random_row());
			end else begin
				queue_word(FuncIgnored, random_row());
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		func = '0;
		col_a = '0;
		col_b = '0;
		col_c = '0;
		col_d = '0;
		out_ready = 1'b0;
		drv_word = '0;
		key_cols_mirror = KeyColsW'(1);
		stored_count = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_words();
		settle();
		write_key_columns(KeyColsW'(MaxColumns));
		fill_past_capacity();
		for (int p = 0; p < 8; p++) begin
			settle();
			write_key_columns(cfg_plan[p]);
			if (p == 7)
				calm = 1'b1;
			random_phase(PHASE_WORDS);
		end
		settle();

		if (failures == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
